// ===== sv/cpm_pkg.sv =====
// ============================================================================
// cpm_pkg
// Shared types and codes of the shared palette merger.
// ============================================================================
package cpm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOUR_BITS_DEF     = 32;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_COLOUR = 2'd1,
        MODE_END    = 2'd2,
        MODE_FINISH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_MAPPED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_ACCEPTED = 3'd3,
        ST_REJECTED = 3'd4,
        ST_FINISHED = 3'd5
    } t_status;

    typedef struct packed {
        logic valid;
        logic fill;
        logic found;
        logic fresh;
    } t_flags;

endpackage

// ===== sv/cpm_if.sv =====
// ============================================================================
// cpm_in_if / cpm_out_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface cpm_in_if;
    logic          valid;
    logic          ready;
    cpm_pkg::t_mode mode;
    logic [31:0]   colour_word;
    logic          is_first_frame;
    logic          has_mask;

    modport source (output valid, mode, colour_word, is_first_frame, has_mask,
                    input ready);
    modport sink   (input valid, mode, colour_word, is_first_frame, has_mask,
                    output ready);
    modport mon    (input valid, ready, mode, colour_word, is_first_frame, has_mask);
endinterface

interface cpm_out_if;
    logic             valid;
    logic             ready;
    cpm_pkg::t_status status;
    logic [7:0]       mapped_index;
    logic [8:0]       palette_count;
    logic             transparent_added;
    logic [7:0]       transparent_index;

    modport source (output valid, status, mapped_index, palette_count,
                    transparent_added, transparent_index, input ready);
    modport sink   (input valid, status, mapped_index, palette_count,
                    transparent_added, transparent_index, output ready);
    modport mon    (input valid, ready, status, mapped_index, palette_count,
                    transparent_added, transparent_index);
endinterface

// ===== sv/cpm_cell.sv =====
// ============================================================================
// cpm_cell
// One palette entry with its destination-used bit; compares, appends and
// passes the search item on to the next cell.
// ============================================================================
module cpm_cell #(
    parameter int PALETTE_ENTRIES = cpm_pkg::PALETTE_ENTRIES_DEF,
    parameter int COLOUR_BITS     = cpm_pkg::COLOUR_BITS_DEF,
    parameter int IDX             = 0,
    localparam int IW             = $clog2(PALETTE_ENTRIES),
    localparam int CW             = $clog2(PALETTE_ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CW-1:0]          i_count,
    input  logic                   i_clear,
    input  cpm_pkg::t_flags        i_flags,
    input  logic [COLOUR_BITS-1:0] i_colour,
    input  logic [IW-1:0]          i_idx,
    output cpm_pkg::t_flags        o_flags,
    output logic [COLOUR_BITS-1:0] o_colour,
    output logic [IW-1:0]          o_idx
);

    localparam logic [CW-1:0] OWN_POS = CW'(IDX);
    localparam logic [IW-1:0] OWN_IDX = IW'(IDX);

    logic [COLOUR_BITS-1:0] r_entry;
    logic                   r_used;
    cpm_pkg::t_flags        r_flags;
    logic [COLOUR_BITS-1:0] r_colour;
    logic [IW-1:0]          r_idx;

    logic            hit;
    logic            take;
    logic            mark;
    cpm_pkg::t_flags n_flags;
    logic [IW-1:0]   n_idx;

    always_comb begin
        hit  = i_flags.valid && !i_flags.fill && !i_flags.found &&
               (OWN_POS < i_count) && (r_entry == i_colour);
        take = i_flags.valid && !i_flags.found && (OWN_POS == i_count);
        mark = hit || (take && !i_flags.fill);
        n_flags = i_flags;
        n_idx   = i_idx;
        if (hit || take) begin
            n_flags.found = 1'b1;
            n_idx         = OWN_IDX;
        end
        if (mark && !r_used) begin
            n_flags.fresh = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
            if (i_clear) begin
                r_used <= 1'b0;
            end else if (mark) begin
                r_used <= 1'b1;
            end
        end
        if (take) begin
            r_entry <= i_colour;
        end
        r_colour <= i_colour;
        r_idx    <= n_idx;
    end

    assign o_flags  = r_flags;
    assign o_colour = r_colour;
    assign o_idx    = r_idx;

endmodule

// ===== sv/common_palette_merger.sv =====
// ============================================================================
// common_palette_merger
// Shared palette builder across animation frames.
// ============================================================================
// Frame start, frame end, a finish that appends nothing and a colour that comes
// after the frame has failed give their result item in the cycle after
// acceptance. Any other used colour, and a finish that appends the transparent
// entry, send a search item down the row of PALETTE_ENTRIES cells, one cell per
// cycle. The result item is registered after the launch register, the cell row
// and the return register; the length of the cell row sets how long such an
// item takes. One item is in work at a time, and the next one is accepted no
// earlier than the edge at which the previous result item is taken.
module common_palette_merger #(
    parameter int PALETTE_ENTRIES = cpm_pkg::PALETTE_ENTRIES_DEF,
    parameter int COLOUR_BITS     = cpm_pkg::COLOUR_BITS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    cpm_in_if.sink   i_item,
    cpm_out_if.source o_result
);

    localparam int IW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam int MW = $clog2(PALETTE_ENTRIES + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state r_state;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_count_start;
    logic [CW-1:0] r_distinct;
    logic [MW-1:0] r_min;
    logic          r_failed;

    cpm_pkg::t_flags        r_launch;
    logic [COLOUR_BITS-1:0] r_launch_colour;
    cpm_pkg::t_flags        r_ret;
    logic [IW-1:0]          r_ret_idx;

    logic             r_out_valid;
    cpm_pkg::t_status r_status;
    logic [7:0]       r_mapped;
    logic [8:0]       r_pc;
    logic             r_t_added;
    logic [7:0]       r_t_index;

    cpm_pkg::t_flags        w_flags  [PALETTE_ENTRIES+1];
    logic [COLOUR_BITS-1:0] w_colour [PALETTE_ENTRIES+1];
    logic [IW-1:0]          w_idx    [PALETTE_ENTRIES+1];

    logic slot_free;
    logic in_fire;
    logic w_clear;
    logic room;

    assign slot_free    = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE) && slot_free;
    assign in_fire      = i_item.valid && i_item.ready;
    assign w_clear      = in_fire && (i_item.mode == cpm_pkg::MODE_START);
    assign room         = r_count < CW'(PALETTE_ENTRIES);

    assign w_flags[0]  = r_launch;
    assign w_colour[0] = r_launch_colour;
    assign w_idx[0]    = '0;

    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
        cpm_cell #(
            .PALETTE_ENTRIES (PALETTE_ENTRIES),
            .COLOUR_BITS     (COLOUR_BITS),
            .IDX             (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_count  (r_count),
            .i_clear  (w_clear),
            .i_flags  (w_flags[g]),
            .i_colour (w_colour[g]),
            .i_idx    (w_idx[g]),
            .o_flags  (w_flags[g+1]),
            .o_colour (w_colour[g+1]),
            .o_idx    (w_idx[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_count_start <= '0;
            r_distinct    <= '0;
            r_min         <= '0;
            r_failed      <= 1'b0;
            r_launch      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_launch <= '0;
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_mapped  <= '0;
                        r_pc      <= 9'(r_count);
                        r_t_added <= 1'b0;
                        r_t_index <= '0;
                        unique case (i_item.mode)
                            cpm_pkg::MODE_START: begin
                                r_count_start <= r_count;
                                r_distinct    <= '0;
                                r_failed      <= 1'b0;
                                r_out_valid   <= 1'b1;
                                r_status      <= cpm_pkg::ST_IGNORED;
                            end
                            cpm_pkg::MODE_COLOUR: begin
                                if (r_failed) begin
                                    r_out_valid <= 1'b1;
                                    r_status    <= cpm_pkg::ST_IGNORED;
                                end else begin
                                    r_launch        <= '{valid: 1'b1, fill: 1'b0,
                                                         found: 1'b0, fresh: 1'b0};
                                    r_launch_colour <= i_item.colour_word[COLOUR_BITS-1:0];
                                    r_state         <= S_SEARCH;
                                end
                            end
                            cpm_pkg::MODE_END: begin
                                r_out_valid <= 1'b1;
                                if (r_failed) begin
                                    r_status <= cpm_pkg::ST_REJECTED;
                                end else begin
                                    r_status <= cpm_pkg::ST_ACCEPTED;
                                    if ((MW'(r_distinct) >= r_min) &&
                                        (!i_item.is_first_frame || i_item.has_mask)) begin
                                        r_min <= MW'(r_distinct) + MW'(1);
                                    end
                                end
                            end
                            cpm_pkg::MODE_FINISH: begin
                                if ((r_min > MW'(r_count)) && room) begin
                                    r_launch        <= '{valid: 1'b1, fill: 1'b1,
                                                         found: 1'b0, fresh: 1'b0};
                                    r_launch_colour <= '0;
                                    r_state         <= S_SEARCH;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_status    <= cpm_pkg::ST_FINISHED;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (w_flags[PALETTE_ENTRIES].valid) begin
                        r_ret     <= w_flags[PALETTE_ENTRIES];
                        r_ret_idx <= w_idx[PALETTE_ENTRIES];
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_mapped    <= '0;
                        r_t_added   <= 1'b0;
                        r_t_index   <= '0;
                        r_state     <= S_IDLE;
                        if (r_ret.fill) begin
                            r_count   <= r_count + CW'(1);
                            r_pc      <= 9'(r_count + CW'(1));
                            r_status  <= cpm_pkg::ST_FINISHED;
                            r_t_added <= 1'b1;
                            r_t_index <= 8'(r_ret_idx);
                        end else if (r_ret.found) begin
                            r_status <= cpm_pkg::ST_MAPPED;
                            r_mapped <= 8'(r_ret_idx);
                            if (CW'(r_ret_idx) == r_count) begin
                                r_count <= r_count + CW'(1);
                                r_pc    <= 9'(r_count + CW'(1));
                            end else begin
                                r_pc <= 9'(r_count);
                            end
                            if (r_ret.fresh) begin
                                r_distinct <= r_distinct + CW'(1);
                            end
                        end else begin
                            r_failed <= 1'b1;
                            r_count  <= r_count_start;
                            r_pc     <= 9'(r_count_start);
                            r_status <= cpm_pkg::ST_FULL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.status            = r_status;
    assign o_result.mapped_index      = r_mapped;
    assign o_result.palette_count     = r_pc;
    assign o_result.transparent_added = r_t_added;
    assign o_result.transparent_index = r_t_index;

endmodule

// ===== sv/cpm_checker.sv =====
// ============================================================================
// cpm_checker
// Port-level checks of the shared palette merger, bound to the top level.
// ============================================================================
module cpm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    cpm_in_if.sink    i_item,
    cpm_out_if.source o_result
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=>
            o_result.valid && $stable(o_result.status) &&
            $stable(o_result.palette_count) && $stable(o_result.mapped_index))
        else $error("Result item changed while stalled.");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready && i_item.mode == cpm_pkg::MODE_START |=>
            o_result.valid && o_result.status == cpm_pkg::ST_IGNORED)
        else $error("Frame start did not answer ignored in the next cycle.");

    a_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status == cpm_pkg::ST_MAPPED |->
            (9'(o_result.mapped_index) < o_result.palette_count) &&
            !o_result.transparent_added)
        else $error("Mapped index lies outside the palette.");

    a_transp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.transparent_added |->
            o_result.status == cpm_pkg::ST_FINISHED &&
            o_result.palette_count == 9'(o_result.transparent_index) + 9'd1)
        else $error("Transparent entry is not the last palette entry.");

endmodule

bind common_palette_merger cpm_checker u_cpm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_item   (i_item),
    .o_result (o_result)
);
